>>> hw/rtl/mpq_pkg.sv
// Shared types and constants for the max priority queue.
package mpq_pkg;

	localparam int CAPACITY    = 64;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int COUNT_OUT_W = 7;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 40;
	localparam int M_TUSER_W   = 3;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

endpackage

>>> hw/rtl/max_priority_queue.sv
// Top level of the max priority queue: cell chain, entry count and output register.
//
//  channel | dir | handshake         | content
//  --------+-----+-------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tuser: kind; tdata: value to insert
//  m_*     | out | m_tvalid/m_tready | tdata: removed value, entry count;
//          |     |                   | tuser: status, empty flag
//
// All cells compare the broadcast value with their own in parallel and shift at the same
// clock edge, so a new item can be accepted each cycle unless the master side stalls.
// The result of an item appears on the master side in the cycle after it is accepted.
// Reset clears the entry count and the output valid flag; the cell contents are not
// reset, because only cells below the entry count are ever read.
// When the master side stalls, the held result blocks the slave side until it is taken.
module max_priority_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mpq_pkg::S_TDATA_W-1:0]     s_tdata,  // [31:0] value
	input  logic                              s_tuser,  // [0] kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mpq_pkg::M_TDATA_W-1:0]     m_tdata,  // [31:0] out_value, [38:32] entry_count
	output logic [mpq_pkg::M_TUSER_W-1:0]     m_tuser   // [1:0] status, [2] queue_empty
);
	import mpq_pkg::*;

	localparam int PAD_W = M_TDATA_W - DATA_W - COUNT_OUT_W;

	logic                     accept;
	logic                     is_full;
	logic                     is_empty;
	cmd_t                     cmd;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_next;
	status_t                  status_next;
	logic signed [DATA_W-1:0] value_chain [CAPACITY];
	logic                     ge_chain    [CAPACITY];

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	status_t                  out_status_q;
	logic [CNT_W-1:0]         out_count_q;
	logic                     out_empty_q;

	// The slave side is open whenever the output register is free or being emptied.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// An insert into a full queue and a remove from an empty one leave the cells alone.
	always_comb begin
		cmd.value   = $signed(s_tdata[DATA_W-1:0]);
		cmd.ins     = accept && (s_tuser == KIND_INSERT) && !is_full;
		cmd.rem     = accept && (s_tuser == KIND_REMOVE) && !is_empty;
		count_next  = count_q;
		status_next = STATUS_OK;
		if (cmd.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_next = count_q - CNT_W'(1);
		end
		if (s_tuser == KIND_INSERT) begin
			if (is_full) begin
				status_next = STATUS_FULL;
			end
		end else if (is_empty) begin
			status_next = STATUS_EMPTY;
		end
	end

	// The chain of cells, kept in descending order from cell 0. Cell 0 always sees a
	// left neighbour that keeps its value, so it takes the new value if it moves at all.
	// The last cell refills from itself on a remove; that slot is then beyond the count.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     occupied;
		logic                     left_ge;
		logic signed [DATA_W-1:0] left_value;
		logic signed [DATA_W-1:0] right_value;

		assign occupied = (count_q > CNT_W'(i));

		if (i == 0) begin : g_first
			assign left_ge    = 1'b1;
			assign left_value = cmd.value;
		end else begin : g_inner
			assign left_ge    = ge_chain[i-1];
			assign left_value = value_chain[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_value = value_chain[i];
		end else begin : g_mid
			assign right_value = value_chain[i+1];
		end

		mpq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (occupied),
			.left_ge     (left_ge),
			.left_value  (left_value),
			.right_value (right_value),
			.value       (value_chain[i]),
			.ge          (ge_chain[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// The output register holds one result until the master side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_value_q  <= cmd.rem ? value_chain[0] : '0;
			out_status_q <= status_next;
			out_count_q  <= count_next;
			out_empty_q  <= (count_next == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, COUNT_OUT_W'(out_count_q), out_value_q};
	assign m_tuser  = {out_empty_q, out_status_q};

	// The entry count never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// A stored insert raises the count by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not raise the count");

	// A remove from an empty queue is reported as such.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == KIND_REMOVE && is_empty) |=> out_status_q == STATUS_EMPTY)
		else $error("remove from empty queue not flagged");

	// The front two cells stay in descending order.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> value_chain[0] >= value_chain[1])
		else $error("front of the queue out of order");

	// The empty flag agrees with the count it is sent with.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_empty_q == (out_count_q == '0)))
		else $error("empty flag disagrees with entry count");

endmodule

>>> hw/rtl/mpq_cell.sv
// One cell of the sorted chain: holds one value and shifts left or right.
module mpq_cell (
	input  logic                             clk,
	input  mpq_pkg::cmd_t                    cmd,
	input  logic                             occupied,
	input  logic                             left_ge,
	input  logic signed [mpq_pkg::DATA_W-1:0] left_value,
	input  logic signed [mpq_pkg::DATA_W-1:0] right_value,
	output logic signed [mpq_pkg::DATA_W-1:0] value,
	output logic                             ge
);
	import mpq_pkg::*;

	logic signed [DATA_W-1:0] store_q;

	// The cell keeps its value when it holds something at least as large as the new one.
	assign ge    = occupied && (store_q >= cmd.value);
	assign value = store_q;

	// The first cell that does not keep its value takes the new one; those after it
	// take their left neighbour's value. A remove pulls every value one cell left.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!ge) begin
				store_q <= left_ge ? cmd.value : left_value;
			end
		end else if (cmd.rem) begin
			store_q <= right_value;
		end
	end

endmodule
